[rtl/core/sht_pkg.sv]
// Shared constants, action codes and controller/datapath interface types.
package sht_pkg;

    localparam int GRID_SIDE_DEF  = 64;
    localparam int WAYS_DEF       = 4;
    localparam int COORD_BITS_DEF = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int ACTION_BITS  = 3;
    localparam int DATA_IN_BITS = 16;

    localparam logic [ACTION_BITS-1:0] ACT_SET          = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_GET          = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE       = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_INCREMENT    = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_DECREMENT    = 3'd4;
    localparam logic [ACTION_BITS-1:0] ACT_RESERVE      = 3'd5;
    localparam logic [ACTION_BITS-1:0] ACT_GET_RESERVED = 3'd6;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR        = 3'd7;

    typedef struct packed {
        logic load_in;    // capture the incoming item
        logic hash_step;  // one remainder step for both coordinates
        logic rd_en;      // read the bucket row
        logic eval;       // update the row and load the result
        logic clr_res;    // load the all-zero result of a clear
        logic clr_wr;     // invalidate one row of the sweep
    } cmd_t;

    typedef struct packed {
        logic is_clear;   // incoming item is a clear
        logic hash_last;  // final remainder step
        logic clr_last;   // final row of the sweep
        logic slot_free;  // output register can take a result
    } sts_t;

endpackage

[rtl/core/sht_ram.sv]
// Generic simple dual-port RAM with registered read.
module sht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/sht_ctrl.sv]
// Controller state machine: clearing sweep, hashing, bucket read and update.
module sht_ctrl
    import sht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_EVAL   = 3'd4;
    localparam logic [2:0] S_CLRRES = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = sts.is_clear ? S_CLRRES : S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (sts.slot_free)
                begin
                    cmd.eval   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLRRES:
            begin
                if (sts.slot_free)
                begin
                    cmd.clr_res = 1'b1;
                    state_next  = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/core/sht_dp.sv]
// Datapath: bucket hashing, row memories, way match and update, result register.
module sht_dp
    import sht_pkg::*;
#(
    parameter int GRID_SIDE  = GRID_SIDE_DEF,
    parameter int WAYS       = WAYS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    output sts_t                          sts,
    input  logic [ACTION_BITS-1:0]        action,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_z,
    input  logic signed [DATA_IN_BITS-1:0] data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_BITS-1:0]  read_value,
    output logic signed [VALUE_BITS-1:0]  read_reserved,
    output logic                          key_found,
    output logic                          bucket_full
);

    localparam int ROWS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDRW = $clog2(ROWS);
    localparam int IDXW  = $clog2(GRID_SIDE);
    localparam int CW    = COORD_BITS + 1;
    localparam int SHIFT = COORD_BITS + IDXW;
    localparam int PW    = 2 * COORD_BITS + 1;
    localparam int WB    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KEYW  = 2 * COORD_BITS;
    localparam int KROW  = WAYS + WAYS * KEYW;
    localparam int VROW  = WAYS * VALUE_BITS;
    // floor(2^SHIFT / GRID_SIDE): the quotient estimate is low by at most one
    localparam logic [CW-1:0] RECIP = CW'((64'd1 << SHIFT) / 64'(GRID_SIDE));
    localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VONE = VALUE_BITS'(1);
    localparam logic signed [VALUE_BITS-1:0] VNEG = '1;

    // item registers
    logic [ACTION_BITS-1:0]       action_reg;
    logic [COORD_BITS-1:0]        x_reg;
    logic [COORD_BITS-1:0]        z_reg;
    logic signed [VALUE_BITS-1:0] data_reg;
    logic [COORD_BITS-1:0]        ax_reg;
    logic [COORD_BITS-1:0]        az_reg;
    logic [COORD_BITS-1:0]        qx_reg;
    logic [COORD_BITS-1:0]        qz_reg;
    logic [IDXW-1:0]              rx_reg;
    logic [IDXW-1:0]              rz_reg;
    logic                         cnt_reg;
    logic [ADDRW-1:0]             clr_cnt_reg;

    logic [COORD_BITS-1:0] ax_in;
    logic [COORD_BITS-1:0] az_in;
    logic [PW-1:0]         px;
    logic [PW-1:0]         pz;
    logic [CW-1:0]         dx;
    logic [CW-1:0]         dz;
    logic [CW-1:0]         rx_next;
    logic [CW-1:0]         rz_next;
    logic [ADDRW-1:0]      row_addr;

    assign ax_in = coord_x[COORD_BITS-1] ? COORD_BITS'(-coord_x) : coord_x;
    assign az_in = coord_z[COORD_BITS-1] ? COORD_BITS'(-coord_z) : coord_z;

    // remainder by reciprocal: quotient estimate, then one correcting subtract
    assign px      = PW'(ax_reg) * PW'(RECIP);
    assign pz      = PW'(az_reg) * PW'(RECIP);
    assign dx      = CW'(ax_reg) - CW'(qx_reg) * CW'(GRID_SIDE);
    assign dz      = CW'(az_reg) - CW'(qz_reg) * CW'(GRID_SIDE);
    assign rx_next = (dx >= CW'(GRID_SIDE)) ? dx - CW'(GRID_SIDE) : dx;
    assign rz_next = (dz >= CW'(GRID_SIDE)) ? dz - CW'(GRID_SIDE) : dz;

    assign row_addr = ADDRW'(rx_reg) * ADDRW'(GRID_SIDE) + ADDRW'(rz_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            action_reg <= action;
            x_reg      <= coord_x;
            z_reg      <= coord_z;
            data_reg   <= VALUE_BITS'(data_in);
            ax_reg     <= ax_in;
            az_reg     <= az_in;
        end
        else if (cmd.hash_step)
        begin
            if (!cnt_reg)
            begin
                qx_reg <= COORD_BITS'(px >> SHIFT);
                qz_reg <= COORD_BITS'(pz >> SHIFT);
            end
            else
            begin
                rx_reg <= IDXW'(rx_next);
                rz_reg <= IDXW'(rz_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                cnt_reg <= 1'b0;
            end
            else if (cmd.hash_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= sts.clr_last ? '0 : clr_cnt_reg + 1'b1;
            end
        end
    end

    assign sts.is_clear  = (action == ACT_CLEAR);
    assign sts.hash_last = cnt_reg;
    assign sts.clr_last  = (clr_cnt_reg == ADDRW'(ROWS - 1));

    // row memories
    logic [KROW-1:0] krow_rd;
    logic [KROW-1:0] krow_wr;
    logic [VROW-1:0] vrow_rd;
    logic [VROW-1:0] vrow_wr;
    logic [VROW-1:0] rrow_rd;
    logic [VROW-1:0] rrow_wr;
    logic [KROW-1:0] kram_wdata;
    logic [ADDRW-1:0] kram_waddr;

    assign kram_wdata = cmd.clr_wr ? '0 : krow_wr;
    assign kram_waddr = cmd.clr_wr ? clr_cnt_reg : row_addr;

    sht_ram #(.WIDTH(KROW), .DEPTH(ROWS)) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.clr_wr | cmd.eval),
        .wr_addr (kram_waddr),
        .wr_data (kram_wdata),
        .rd_en   (cmd.rd_en),
        .rd_addr (row_addr),
        .rd_data (krow_rd)
    );

    sht_ram #(.WIDTH(VROW), .DEPTH(ROWS)) u_value_ram (
        .clk     (clk),
        .wr_en   (cmd.eval),
        .wr_addr (row_addr),
        .wr_data (vrow_wr),
        .rd_en   (cmd.rd_en),
        .rd_addr (row_addr),
        .rd_data (vrow_rd)
    );

    sht_ram #(.WIDTH(VROW), .DEPTH(ROWS)) u_resv_ram (
        .clk     (clk),
        .wr_en   (cmd.eval),
        .wr_addr (row_addr),
        .wr_data (rrow_wr),
        .rd_en   (cmd.rd_en),
        .rd_addr (row_addr),
        .rd_data (rrow_rd)
    );

    // way match and row update
    logic [WAYS-1:0]                 valid_old;
    logic [WAYS-1:0][KEYW-1:0]       keys_old;
    logic [WAYS-1:0][VALUE_BITS-1:0] vals_old;
    logic [WAYS-1:0][VALUE_BITS-1:0] resv_old;
    logic [WAYS-1:0]                 valid_new;
    logic [WAYS-1:0][KEYW-1:0]       keys_new;
    logic [WAYS-1:0][VALUE_BITS-1:0] vals_new;
    logic [WAYS-1:0][VALUE_BITS-1:0] resv_new;
    logic                            found;
    logic                            has_free;
    logic [WB-1:0]                   hit;
    logic [WB-1:0]                   freew;
    logic signed [VALUE_BITS-1:0]    hv;
    logic signed [VALUE_BITS-1:0]    nv;
    logic signed [VALUE_BITS-1:0]    rv;
    logic signed [VALUE_BITS-1:0]    rr;
    logic                            full;

    assign valid_old = krow_rd[WAYS-1:0];
    assign keys_old  = krow_rd[KROW-1:WAYS];
    assign vals_old  = vrow_rd;
    assign resv_old  = rrow_rd;
    assign krow_wr   = {keys_new, valid_new};
    assign vrow_wr   = vals_new;
    assign rrow_wr   = resv_new;

    always_comb
    begin
        found    = 1'b0;
        has_free = 1'b0;
        hit      = '0;
        freew    = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (valid_old[w])
            begin
                if (!found && keys_old[w] == {x_reg, z_reg})
                begin
                    found = 1'b1;
                    hit   = WB'(w);
                end
            end
            else if (!has_free)
            begin
                has_free = 1'b1;
                freew    = WB'(w);
            end
        end
    end

    assign hv = vals_old[hit];
    assign nv = (hv > VMIN) ? hv - VONE : hv;

    always_comb
    begin
        valid_new = valid_old;
        keys_new  = keys_old;
        vals_new  = vals_old;
        resv_new  = resv_old;
        rv        = '0;
        rr        = '0;
        full      = 1'b0;
        if (found)
        begin
            case (action_reg)
                ACT_SET:       vals_new[hit] = data_reg;
                ACT_GET:       rv = hv;
                ACT_DELETE:    valid_new[hit] = 1'b0;
                ACT_INCREMENT: vals_new[hit] = (hv < VMAX) ? hv + VONE : hv;
                ACT_DECREMENT:
                begin
                    vals_new[hit] = nv;
                    if (nv <= 0)
                    begin
                        valid_new[hit] = 1'b0;
                    end
                end
                ACT_RESERVE:   resv_new[hit] = data_reg;
                default:       rr = resv_old[hit];
            endcase
        end
        else if (action_reg inside {ACT_SET, ACT_INCREMENT, ACT_RESERVE})
        begin
            if (!has_free)
            begin
                full = 1'b1;
            end
            else
            begin
                valid_new[freew] = 1'b1;
                keys_new[freew]  = {x_reg, z_reg};
                vals_new[freew]  = (action_reg == ACT_SET) ? data_reg :
                                   (action_reg == ACT_INCREMENT) ? VONE : VNEG;
                resv_new[freew]  = (action_reg == ACT_RESERVE) ? data_reg : '0;
            end
        end
    end

    // result register
    logic                         out_valid_reg;
    logic signed [VALUE_BITS-1:0] rv_reg;
    logic signed [VALUE_BITS-1:0] rr_reg;
    logic                         found_reg;
    logic                         full_reg;

    assign sts.slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.eval || cmd.clr_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            rv_reg    <= rv;
            rr_reg    <= rr;
            found_reg <= found;
            full_reg  <= full;
        end
        else if (cmd.clr_res)
        begin
            rv_reg    <= '0;
            rr_reg    <= '0;
            found_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_value    = rv_reg;
    assign read_reserved = rr_reg;
    assign key_found     = found_reg;
    assign bucket_full   = full_reg;

endmodule

[rtl/core/spatial_hash_count_table.sv]
// Top level of the spatial hash count table.
// From accept to result: bucket remainder (reciprocal estimate, then correction),
// then the row read and the update, which loads the result register.
// No new item is taken until the last is done; a stalled result holds the update back.
// A clear answers first, then sweeps GRID_SIDE * GRID_SIDE rows, one per cycle.
// Reset: asynchronous; afterwards the same sweep runs before the first item is taken.
module spatial_hash_count_table
    import sht_pkg::*;
#(
    parameter int GRID_SIDE  = GRID_SIDE_DEF,
    parameter int WAYS       = WAYS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ACTION_BITS-1:0]         action,
    input  logic signed [COORD_BITS-1:0]   coord_x,
    input  logic signed [COORD_BITS-1:0]   coord_z,
    input  logic signed [DATA_IN_BITS-1:0] data_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [VALUE_BITS-1:0]   read_value,
    output logic signed [VALUE_BITS-1:0]   read_reserved,
    output logic                           key_found,
    output logic                           bucket_full
);

    cmd_t cmd;
    sts_t sts;

    sht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sht_dp #(
        .GRID_SIDE  (GRID_SIDE),
        .WAYS       (WAYS),
        .COORD_BITS (COORD_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .coord_x       (coord_x),
        .coord_z       (coord_z),
        .data_in       (data_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_value    (read_value),
        .read_reserved (read_reserved),
        .key_found     (key_found),
        .bucket_full   (bucket_full)
    );

endmodule
